// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL; vrq_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define VRQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define VRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define VRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vrq_pkg.sv =====
// Types and constants of the variable record ring queue.
package vrq_pkg;

  localparam int unsigned LEN_W      = 13;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned PTR_W      = 13;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_DATA_W-1:0] QUEUE_BYTES_RST = 13'd4096;
  localparam logic [CFG_DATA_W-1:0] MAX_BLOCK_RST   = 13'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK   = 8'd1;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_A,
    S_PUSH_B,
    S_POP_A,
    S_POP_B
  } fsm_e;

  typedef struct packed {
    logic             pad;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } hdr_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    hdr_t             wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== hdl/vrq_if.sv =====
// Handshake channel interfaces: request, response and configuration write.
interface vrq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [vrq_pkg::LEN_W-1:0]  rec_length;
  logic [vrq_pkg::TAG_W-1:0]  rec_tag;
  modport source (output valid, req_type, rec_length, rec_tag, input ready);
  modport sink   (input valid, req_type, rec_length, rec_tag, output ready);
endinterface

interface vrq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vrq_pkg::STAT_W-1:0] status;
  logic [vrq_pkg::OFF_W-1:0]  rec_offset;
  logic [vrq_pkg::LEN_W-1:0]  out_length;
  logic [vrq_pkg::TAG_W-1:0]  out_tag;
  modport source (output valid, status, rec_offset, out_length, out_tag, input ready);
  modport sink   (input valid, status, rec_offset, out_length, out_tag, output ready);
endinterface

interface vrq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vrq_pkg::CFG_IDX_W-1:0]  index;
  logic [vrq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/vrq_hdr_mem.sv =====
// Header store: single write port, single registered read port.
module vrq_hdr_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic              clk_i,
  input  vrq_pkg::mem_req_t mem_req_i,
  output vrq_pkg::hdr_t     rd_data_o
);
  import vrq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hdr_t mem_q [DEPTH];
  hdr_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr[AW-1:0]] <= mem_req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/vrq_ctrl.sv =====
// Pointer sequencer, configuration registers and response register.
`include "assert_macros.svh"

module vrq_ctrl #(
  parameter int unsigned CAPACITY_BYTES = 4096,
  parameter int unsigned START_OFFSET   = 8,
  parameter int unsigned HEADER_BYTES   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vrq_req_if.sink           req,
  vrq_rsp_if.source         rsp,
  vrq_cfg_if.sink           cfg,
  output vrq_pkg::mem_req_t mem_req_o,
  input  vrq_pkg::hdr_t     rd_data_i
);
  import vrq_pkg::*;

  localparam int unsigned PTR_MAX  = (1 << PTR_W) - 1;
  localparam int unsigned RING_MAX = (CAPACITY_BYTES < PTR_MAX) ? CAPACITY_BYTES : PTR_MAX;
  localparam logic [PTR_W-1:0] START = PTR_W'(START_OFFSET);
  localparam logic [LEN_W-1:0] HDR   = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] RMAX  = LEN_W'(RING_MAX);
  localparam logic [LEN_W-1:0] RMIN  = LEN_W'(START_OFFSET + HEADER_BYTES);

  fsm_e state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CFG_DATA_W-1:0] qbytes_q, maxblk_q;
  logic [LEN_W-1:0] req_len_q;
  logic [TAG_W-1:0] req_tag_q;
  logic req_pop_q;
  logic rd_oob_q;

  logic rsp_valid_q;
  status_e rsp_status_q, res_status;
  logic [OFF_W-1:0] rsp_off_q, res_off;
  logic [LEN_W-1:0] rsp_len_q, res_len;
  logic [TAG_W-1:0] rsp_tag_q, res_tag;
  logic fin;

  logic req_acc, out_free;
  logic [LEN_W-1:0] ring_len, surplus, room_tail;
  logic too_short, too_large, wrap, wrap_full, full_b, empty_now, skip;
  logic [PTR_W+1:0] full_lim;
  hdr_t hdr_eff;
  mem_req_t mreq;

  assign req_acc  = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !rsp_valid_q || rsp.ready;

  // Saturate the ring length into its legal range.
  always_comb begin
    ring_len = (qbytes_q > RMAX) ? RMAX : qbytes_q;
    if (ring_len < RMIN) begin
      ring_len = RMIN;
    end
  end

  assign too_short = req_len_q < HDR;
  assign too_large = (req_len_q > maxblk_q) || (req_len_q > (ring_len - START));
  assign surplus   = (head_q < ring_len) ? (ring_len - head_q) : '0;
  assign wrap      = surplus < req_len_q;
  assign wrap_full = wrap && (tail_q == START);
  assign full_lim  = {2'b00, head_q} + {2'b00, req_len_q} + {2'b00, maxblk_q};
  assign full_b    = (tail_q > head_q) && ({2'b00, tail_q} < full_lim);

  assign hdr_eff   = rd_oob_q ? hdr_t'('0) : rd_data_i;
  assign empty_now = (tail_q == head_q);
  assign room_tail = (tail_q < ring_len) ? (ring_len - tail_q) : '0;
  assign skip      = (head_q < tail_q) && ((room_tail < HDR) || hdr_eff.pad);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = (req.req_type == REQ_POP) ? S_POP_A : S_PUSH_A;
        end
      end
      S_PUSH_A: begin
        if (too_short || too_large || wrap_full) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_PUSH_B;
        end
      end
      S_PUSH_B: begin
        if (out_free) state_d = S_IDLE;
      end
      S_POP_A: begin
        if (!empty_now && skip) begin
          state_d = S_POP_B;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_POP_B: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pointer updates, memory requests and result.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    mreq       = '0;
    fin        = 1'b0;
    res_status = ST_OK;
    res_off    = '0;
    res_len    = '0;
    res_tag    = '0;
    unique case (state_q)
      S_IDLE: begin
        mreq.rd_en   = req_acc;
        mreq.rd_addr = tail_q;
      end
      S_PUSH_A: begin
        priority if (too_short) begin
          fin        = out_free;
          res_status = ST_SHORT;
        end else if (too_large) begin
          fin        = out_free;
          res_status = ST_TOO_LARGE;
        end else if (wrap_full) begin
          fin        = out_free;
          res_status = ST_FULL;
        end else if (wrap) begin
          priority if (tail_q > head_q) begin
            tail_d = START;
            head_d = START;
          end else if (surplus < HDR) begin
            head_d = START;
          end else begin
            // Fill the ring end with a pad record.
            mreq.wr_en        = 1'b1;
            mreq.wr_addr      = head_q;
            mreq.wr_data.pad  = 1'b1;
            mreq.wr_data.len  = surplus;
            mreq.wr_data.tag  = '0;
            head_d            = START;
          end
        end else begin
          // Room left at the head: go straight on to the full check.
        end
      end
      S_PUSH_B: begin
        if (out_free) begin
          fin = 1'b1;
          if (full_b) begin
            res_status = ST_FULL;
          end else begin
            mreq.wr_en       = 1'b1;
            mreq.wr_addr     = head_q;
            mreq.wr_data.pad = 1'b0;
            mreq.wr_data.len = req_len_q;
            mreq.wr_data.tag = req_tag_q;
            res_off          = head_q[OFF_W-1:0];
            head_d           = head_q + req_len_q;
          end
        end
      end
      S_POP_A: begin
        if (empty_now) begin
          fin        = out_free;
          res_status = ST_EMPTY;
        end else if (skip) begin
          // Skip pad or short tail end: restart at the ring start and reread.
          tail_d       = START;
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = START;
        end else if (out_free) begin
          fin     = 1'b1;
          res_off = tail_q[OFF_W-1:0];
          res_len = hdr_eff.len;
          res_tag = hdr_eff.tag;
          tail_d  = tail_q + hdr_eff.len;
        end
      end
      S_POP_B: begin
        if (out_free) begin
          fin = 1'b1;
          if (empty_now) begin
            res_status = ST_EMPTY;
          end else begin
            res_off = tail_q[OFF_W-1:0];
            res_len = hdr_eff.len;
            res_tag = hdr_eff.tag;
            tail_d  = tail_q + hdr_eff.len;
          end
        end
      end
      default: ;
    endcase
  end

  assign mem_req_o = mreq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= START;
      tail_q      <= START;
      qbytes_q    <= QUEUE_BYTES_RST;
      maxblk_q    <= MAX_BLOCK_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_QUEUE_BYTES: qbytes_q <= cfg.data;
          CFG_MAX_BLOCK:   maxblk_q <= cfg.data;
          default: ;
        endcase
      end
      if (fin) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_pop_q <= req.req_type;
      req_len_q <= req.rec_length;
      req_tag_q <= req.rec_tag;
    end
    if (mreq.rd_en) begin
      rd_oob_q <= (32'(mreq.rd_addr) >= CAPACITY_BYTES);
    end
    if (fin) begin
      rsp_status_q <= res_status;
      rsp_off_q    <= res_off;
      rsp_len_q    <= res_len;
      rsp_tag_q    <= res_tag;
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.status     = rsp_status_q;
  assign rsp.rec_offset = rsp_off_q;
  assign rsp.out_length = rsp_len_q;
  assign rsp.out_tag    = rsp_tag_q;

  `VRQ_ASSERT_IMP(a_wr_only_push, clk_i, rst_ni, mreq.wr_en,
    (state_q == S_PUSH_A || state_q == S_PUSH_B), "header write outside a push")
  `VRQ_ASSERT_IMP(a_fin_free, clk_i, rst_ni, fin, out_free,
    "result loaded over an unread response")
  `VRQ_ASSERT_NXT(a_idle_ptr, clk_i, rst_ni, state_q == S_IDLE,
    $stable(head_q) && $stable(tail_q), "pointers moved while idle")
  `VRQ_ASSERT_IMP(a_pop_type, clk_i, rst_ni,
    (state_q == S_POP_A || state_q == S_POP_B), req_pop_q == REQ_POP,
    "pop sequence on a push request")

endmodule

// ===== hdl/variable_record_ring_queue_core.sv =====
// Top level of the variable record ring queue: sequencer plus header store.
//
//  channel  dir  modport  payload
//  req_i    in   sink     req_type, rec_length, rec_tag
//  rsp_o    out  source   status, rec_offset, out_length, out_tag
//  cfg_i    in   sink     index, data (0 queue_bytes, 1 max_block)
//
// A push runs accept, wrap step and header write, or ends at the wrap step if
// refused at the length or wrap check; a pop reads the tail header, or rereads
// the start offset to skip a pad or short tail end. The next request is taken
// the cycle after the response loads. Reset is asynchronous and active low;
// the header store needs no clearing. A held response stalls only the final
// step; a new request is taken while a finished response waits.
module variable_record_ring_queue_core #(
  parameter int unsigned CAPACITY_BYTES = 4096,
  parameter int unsigned START_OFFSET   = 8,
  parameter int unsigned HEADER_BYTES   = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  vrq_req_if.sink     req_i,
  vrq_rsp_if.source   rsp_o,
  vrq_cfg_if.sink     cfg_i
);
  import vrq_pkg::*;

  localparam int unsigned MEM_DEPTH =
    (CAPACITY_BYTES < (1 << PTR_W)) ? CAPACITY_BYTES : (1 << PTR_W);

  mem_req_t mem_req;
  hdr_t     rd_data;

  vrq_ctrl #(
    .CAPACITY_BYTES (CAPACITY_BYTES),
    .START_OFFSET   (START_OFFSET),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .rsp       (rsp_o),
    .cfg       (cfg_i),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  vrq_hdr_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// ===== test/variable_record_ring_queue_core_tb.sv =====
// Self-checking testbench for variable_record_ring_queue_core: directed table, then random phases.
`timescale 1ns / 1ps

module variable_record_ring_queue_core_tb;
  import vrq_pkg::*;

  localparam int unsigned RING_CAP        = 4096;
  localparam int unsigned RING_START      = 8;
  localparam int unsigned HDR_BYTES       = 16;
  localparam int unsigned NUM_SETUPS      = 11;
  localparam int unsigned ITEMS_PER_SETUP = 123;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
  } rsp_t;

  typedef struct {
    logic              op;
    logic [LEN_W-1:0]  len;
    logic [TAG_W-1:0]  tag;
    bit                typed;
    rsp_t              want;
  } dir_row_t;

  localparam rsp_t R_NONE  = '0;
  localparam rsp_t R_EMPTY = '{ST_EMPTY, '0, '0, '0};
  localparam rsp_t R_FULL  = '{ST_FULL, '0, '0, '0};
  localparam rsp_t R_SHORT = '{ST_SHORT, '0, '0, '0};
  localparam rsp_t R_LARGE = '{ST_TOO_LARGE, '0, '0, '0};

  // Reset settings first, then the extremes and a few in between.
  localparam logic [CFG_DATA_W-1:0] SETUP_QB [NUM_SETUPS] = '{
    13'd4096, 13'd64, 13'd64, 13'd4096, 13'h1FFF, 13'd0,
    13'd300, 13'd1000, 13'd4096, 13'd200, 13'd2048
  };
  localparam logic [CFG_DATA_W-1:0] SETUP_MB [NUM_SETUPS] = '{
    13'd1024, 13'd16, 13'd4096, 13'd16, 13'h1FFF, 13'd200,
    13'd64, 13'd300, 13'd4096, 13'd100, 13'd512
  };

  dir_row_t dir_table [24] = '{
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b1, R_EMPTY},
    '{REQ_PUSH, 13'd0,    32'h0000_0000, 1'b1, R_SHORT},
    '{REQ_PUSH, 13'd15,   32'hFFFF_FFFF, 1'b1, R_SHORT},
    '{REQ_PUSH, 13'd1025, 32'h1234_5678, 1'b1, R_LARGE},
    '{REQ_PUSH, 13'h1FFF, 32'hFFFF_FFFF, 1'b1, R_LARGE},
    '{REQ_PUSH, 13'd16,   32'h0000_0000, 1'b1, '{ST_OK, 12'd8, 13'd0, 32'd0}},
    '{REQ_PUSH, 13'd1024, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 12'd24, 13'd0, 32'd0}},
    '{REQ_POP,  13'h1FFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 12'd8, 13'd16, 32'd0}},
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b1, '{ST_OK, 12'd24, 13'd1024, 32'hFFFF_FFFF}},
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b1, R_EMPTY},
    '{REQ_PUSH, 13'd1024, 32'hA5A5_A5A5, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd1024, 32'h5A5A_5A5A, 1'b0, R_NONE},
    // wrap writes a pad record, then the tail is too close
    '{REQ_PUSH, 13'd1024, 32'hC0DE_0001, 1'b1, R_FULL},
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b0, R_NONE},
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b0, R_NONE},
    // skip the pad, ring is then empty
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd1000, 32'h0000_1000, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd1024, 32'h0000_2000, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd1024, 32'h0000_3000, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd1024, 32'h0000_4000, 1'b0, R_NONE},
    '{REQ_PUSH, 13'd16,   32'h0000_5000, 1'b0, R_NONE},
    // head at ring end, tail at start
    '{REQ_PUSH, 13'd16,   32'h0000_6000, 1'b1, R_FULL},
    '{REQ_POP,  13'd0,    32'h0000_0000, 1'b0, R_NONE},
    // wrap without room for a pad, then full
    '{REQ_PUSH, 13'd100,  32'h0000_7000, 1'b0, R_NONE}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm_run;

  vrq_req_if req_if ();
  vrq_rsp_if rsp_if ();
  vrq_cfg_if cfg_if ();

  variable_record_ring_queue_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Ring state mirrored at request acceptance.
  logic [CFG_DATA_W-1:0] ring_qbytes;
  logic [CFG_DATA_W-1:0] ring_maxblk;
  int unsigned           ring_head;
  int unsigned           ring_tail;
  hdr_t                  hdr_mem  [RING_CAP];
  bit                    hdr_seen [RING_CAP];

  rsp_t        rsp_pending [$];
  int unsigned mismatch_cnt;

  function automatic int unsigned ring_span();
    int unsigned l;
    l = ring_qbytes;
    if (l > RING_CAP) l = RING_CAP;
    if (l < RING_START + HDR_BYTES) l = RING_START + HDR_BYTES;
    return l;
  endfunction

  function automatic void store_header(input int unsigned pos, input logic pad,
                                       input int unsigned len, input logic [TAG_W-1:0] tag);
    if (pos < RING_CAP) begin
      hdr_mem[pos]  = '{pad: pad, len: LEN_W'(len), tag: tag};
      hdr_seen[pos] = 1'b1;
    end
  endfunction

  function automatic rsp_t ring_push(input int unsigned len, input logic [TAG_W-1:0] tag);
    int unsigned span;
    int unsigned surplus;
    rsp_t        r;
    span = ring_span();
    r = '0;
    if (len < HDR_BYTES) begin
      r.status = ST_SHORT;
      return r;
    end
    if (len > ring_maxblk || len > span - RING_START) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    surplus = (ring_head < span) ? span - ring_head : 0;
    if (surplus < len) begin
      if (ring_tail == RING_START) begin
        r.status = ST_FULL;
        return r;
      end else if (ring_tail > ring_head) begin
        ring_tail = RING_START;
        ring_head = RING_START;
      end else if (surplus < HDR_BYTES) begin
        ring_head = RING_START;
      end else begin
        store_header(ring_head, 1'b1, surplus, '0);
        ring_head = RING_START;
      end
    end
    if (ring_tail > ring_head && ring_tail < ring_head + len + ring_maxblk) begin
      r.status = ST_FULL;
      return r;
    end
    store_header(ring_head, 1'b0, len, tag);
    r.status = ST_OK;
    r.offset = OFF_W'(ring_head);
    ring_head += len;
    return r;
  endfunction

  function automatic rsp_t ring_pop();
    int unsigned span;
    hdr_t        h;
    rsp_t        r;
    span = ring_span();
    r = '0;
    r.status = ST_EMPTY;
    if (ring_tail == ring_head) return r;
    if (ring_head < ring_tail) begin
      if (ring_tail >= span || span - ring_tail < HDR_BYTES || hdr_mem[ring_tail].pad)
        ring_tail = RING_START;
    end
    if (ring_tail == ring_head) return r;
    h = hdr_mem[ring_tail];
    r.status = ST_OK;
    r.offset = OFF_W'(ring_tail);
    r.length = h.len;
    r.tag    = h.tag;
    ring_tail += h.len;
    return r;
  endfunction

  // True when a pop now would read a header entry that was never written.
  function automatic bit ring_pop_blank();
    int unsigned span;
    int unsigned t;
    span = ring_span();
    t = ring_tail;
    if (t == ring_head) return 1'b0;
    if (ring_head < t) begin
      if (t >= span || span - t < HDR_BYTES) t = RING_START;
      else if (!hdr_seen[t]) return 1'b1;
      else if (hdr_mem[t].pad) t = RING_START;
    end
    if (t == ring_head) return 1'b0;
    return t >= RING_CAP || !hdr_seen[t];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 100)
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Hold the request until accepted, then advance the ring state.
  task automatic send_request(input logic op, input logic [LEN_W-1:0] len,
                              input logic [TAG_W-1:0] tag, input bit typed,
                              input rsp_t typed_rsp);
    int unsigned gap;
    rsp_t        r;
    if (!calm_run && $urandom_range(99) < 6) begin
      gap = $urandom_range(4, 1);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.rec_length <= len;
    req_if.rec_tag    <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    r = (op == REQ_PUSH) ? ring_push(len, tag) : ring_pop();
    rsp_pending.push_back(typed ? typed_rsp : r);
  endtask

  task automatic load_ring_setup(input logic [CFG_DATA_W-1:0] qbytes,
                                 input logic [CFG_DATA_W-1:0] maxblk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_QUEUE_BYTES;
    cfg_if.data  <= qbytes;
    do @(posedge clk_i); while (!cfg_if.ready);
    ring_qbytes = qbytes;
    cfg_if.index <= CFG_MAX_BLOCK;
    cfg_if.data  <= maxblk;
    do @(posedge clk_i); while (!cfg_if.ready);
    ring_maxblk = maxblk;
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    rsp_if.ready <= calm_run || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_pending.size() == 0) begin
        report_mismatch("response with no request pending", 32'(rsp_if.status), '0);
      end else begin
        want = rsp_pending.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.rec_offset !== want.offset)
          report_mismatch("rec_offset", 32'(rsp_if.rec_offset), 32'(want.offset));
        if (rsp_if.out_length !== want.length)
          report_mismatch("out_length", 32'(rsp_if.out_length), 32'(want.length));
        if (rsp_if.out_tag !== want.tag)
          report_mismatch("out_tag", rsp_if.out_tag, want.tag);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("[variable_record_ring_queue_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned      ph;
    int unsigned      sent;
    int unsigned      span;
    int unsigned      hi;
    int unsigned      near;
    int unsigned      pick;
    int unsigned      pop_pct;
    logic             op;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_PUSH;
    req_if.rec_length = '0;
    req_if.rec_tag    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_QUEUE_BYTES;
    cfg_if.data       = '0;
    ring_qbytes       = QUEUE_BYTES_RST;
    ring_maxblk       = MAX_BLOCK_RST;
    ring_head         = RING_START;
    ring_tail         = RING_START;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i])
      send_request(dir_table[i].op, dir_table[i].len, dir_table[i].tag,
                   dir_table[i].typed, dir_table[i].want);

    for (ph = 0; ph < NUM_SETUPS; ph++) begin
      // Drain before touching the registers.
      req_if.valid <= 1'b0;
      while (rsp_pending.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      load_ring_setup(SETUP_QB[ph], SETUP_MB[ph]);
      calm_run <= (ph == 3);
      pop_pct = $urandom_range(60, 30);
      sent = 0;
      while (sent < ITEMS_PER_SETUP) begin
        pick = $urandom_range(99);
        tag  = $urandom();
        len  = LEN_W'($urandom());
        op   = REQ_PUSH;
        if (pick < pop_pct) begin
          op = REQ_POP;
        end else if (pick < pop_pct + 4) begin
          len = LEN_W'($urandom_range(HDR_BYTES - 1));
        end else if (pick >= pop_pct + 8) begin
          span = ring_span();
          hi   = (ring_maxblk < span - RING_START) ? ring_maxblk : span - RING_START;
          near = HDR_BYTES + span / 8;
          if (near > hi) near = hi;
          len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(hi, HDR_BYTES))
                                         : LEN_W'($urandom_range(near, HDR_BYTES));
        end
        if (op == REQ_POP && ring_pop_blank()) continue;
        send_request(op, len, tag, 1'b0, R_NONE);
        sent++;
      end
    end

    req_if.valid <= 1'b0;
    calm_run     <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("[variable_record_ring_queue_core] OK");
    else
      $display("[variable_record_ring_queue_core] ERROR");
    $finish;
  end

endmodule
